/* sv/hsc_pkg.sv */
// hsc_pkg: widths, configuration and result types, and constant helper
// functions for the Hamming single-error-correcting codec.
// No dependencies; used by hsc_core and hamming_sec_codec_unit.
package hsc_pkg;

  // Longest code word handled; code positions run 1..CODE_BITS
  localparam int CODE_BITS = 31;
  localparam int WORD_W    = 31;
  localparam int K_W       = 5;   // message length register width
  localparam int R_W       = 3;   // parity count width
  localparam int SYN_W     = 5;   // syndrome / position width
  localparam int N_W       = 5;   // code length width (n <= 31)
  localparam int MAX_PARITY = 5;  // r for the longest code

  // Largest message length whose code fits in CODE_BITS positions
  localparam int K_MAX = 26;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Derived code geometry, settled at reset and at each configuration write
  typedef struct packed {
    logic [K_W-1:0] k;
    logic [R_W-1:0] r;
    logic [N_W-1:0] n;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [R_W-1:0]    parity_count;
    logic [SYN_W-1:0]  syndrome;
    logic              out_of_range;
  } result_t;

  // Smallest r with k + r + 1 <= 2^r
  function automatic logic [R_W-1:0] parity_for(input logic [K_W-1:0] k);
    logic [R_W-1:0] r;
    logic           found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i <= MAX_PARITY; i++) begin
      if (!found && (int'(k) + i + 1 <= (1 << i))) begin
        r     = R_W'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // Clamp a raw register value to a usable message length
  function automatic logic [K_W-1:0] effective_k(input logic [K_W-1:0] raw);
    logic [K_W-1:0] k;
    k = raw;
    if (k == '0) begin
      k = K_W'(1);
    end else if (int'(k) > K_MAX) begin
      k = K_W'(K_MAX);
    end
    return k;
  endfunction

  // Full geometry for a raw register value
  function automatic cfg_t make_cfg(input logic [K_W-1:0] raw);
    cfg_t c;
    c.k = effective_k(raw);
    c.r = parity_for(c.k);
    c.n = N_W'(int'(c.k) + int'(c.r));
    return c;
  endfunction

  function automatic logic is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Message bit that lands in data position p: the count of data positions
  // at or below p, less one. It does not depend on the message length.
  function automatic logic [SYN_W-1:0] msg_index(input int p);
    int cnt;
    cnt = 0;
    for (int q = 1; q <= CODE_BITS; q++) begin
      if (q <= p && !is_pow2(q)) begin
        cnt = cnt + 1;
      end
    end
    return SYN_W'(cnt - 1);
  endfunction

endpackage

/* sv/hamming_sec_codec_unit.sv */
// hamming_sec_codec_unit: top level of the variable-length Hamming codec.
// Depends on hsc_pkg and hsc_core.
//
// Usage:
//   Command channel: drive op and word with start high; a beat is taken at
//   any rising edge with start high and busy low. busy is always low, so a
//   new command may be issued every cycle.
//   op = encode: word carries the message in its low data_bits bits, bit 0
//   in the lowest data position; op = check: word is a code word, bit p-1 is position p.
//   Result channel: done pulses for one cycle with code_word, parity_count,
//   syndrome and out_of_range valid in that same cycle. The receiver cannot
//   stall; each result must be taken when shown.
//   The command passes through the input register and then the result
//   register. Throughput: one word per cycle, set by the single XOR-tree
//   pass between the two registers.
//   Configuration: cfg_valid/cfg_ready/cfg_data write data_bits; cfg_ready
//   is always high. Write only while no command is in flight. Parity count
//   and code length are worked out at the write and held in a register.
//   Reset (rst, synchronous): data_bits returns to 8 (r = 4, n = 12) and no
//   result is pending.
module hamming_sec_codec_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [hsc_pkg::WORD_W-1:0]  word,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsc_pkg::K_W-1:0]     cfg_data,
  output logic                        done,
  output logic [hsc_pkg::WORD_W-1:0]  code_word,
  output logic [hsc_pkg::R_W-1:0]     parity_count,
  output logic [hsc_pkg::SYN_W-1:0]   syndrome,
  output logic                        out_of_range
);
  import hsc_pkg::*;

  localparam logic [K_W-1:0] DATA_BITS_RESET = K_W'(8);

  cfg_t              cfg;
  logic              in_valid;
  logic              in_op;
  logic [WORD_W-1:0] in_word;
  result_t           res_next;
  result_t           res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register with derived geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= make_cfg(DATA_BITS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      cfg <= make_cfg(cfg_data);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op   <= op;
      in_word <= word;
    end
  end

  hsc_core u_core (
    .op   (in_op),
    .word (in_word),
    .cfg  (cfg),
    .res  (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res <= res_next;
    end
  end

  assign code_word    = res.code_word;
  assign parity_count = res.parity_count;
  assign syndrome     = res.syndrome;
  assign out_of_range = res.out_of_range;

  // Checks
  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result beat without a command two cycles earlier");

  a_parity_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (parity_count >= R_W'(2)) && (parity_count <= R_W'(MAX_PARITY)))
    else $error("parity count out of range");

  a_oor_has_syndrome: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (syndrome != '0))
    else $error("out-of-range flag with zero syndrome");

  a_cfg_geometry: assert property (@(posedge clk) disable iff (rst)
    (cfg.n == N_W'(int'(cfg.k) + int'(cfg.r))) && (int'(cfg.n) <= CODE_BITS))
    else $error("code geometry inconsistent");

endmodule

/* sv/hsc_core.sv */
// hsc_core: combinational encode / check-and-correct datapath for one word.
// Depends on hsc_pkg.
module hsc_core (
  input  logic                        op,
  input  logic [hsc_pkg::WORD_W-1:0]  word,
  input  hsc_pkg::cfg_t               cfg,
  output hsc_pkg::result_t            res
);
  import hsc_pkg::*;

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] data_cw;
  logic [WORD_W-1:0] enc_cw;
  logic [WORD_W-1:0] chk_cw;
  logic [WORD_W-1:0] flip;
  logic [SYN_W-1:0]  syn_enc;
  logic [SYN_W-1:0]  syn_chk;
  logic              oor;

  // Positions in use, and message scatter into the data positions
  always_comb begin
    mask    = '0;
    data_cw = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      mask[p-1] = ((N_W+1)'(p) <= {1'b0, cfg.n});
      if (!is_pow2(p)) begin
        data_cw[p-1] = mask[p-1] & word[msg_index(p)];
      end
    end
  end

  // Syndrome of the scattered data; its bits are the parity bits
  always_comb begin
    syn_enc = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (data_cw[p-1]) begin
        syn_enc = syn_enc ^ SYN_W'(p);
      end
    end
    enc_cw = data_cw;
    for (int i = 0; i < MAX_PARITY; i++) begin
      enc_cw[(1 << i) - 1] = syn_enc[i];
    end
  end

  // Check: syndrome over the masked word, flip the named position unless it lies beyond n
  always_comb begin
    syn_chk = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (word[p-1] && mask[p-1]) begin
        syn_chk = syn_chk ^ SYN_W'(p);
      end
    end
    oor  = ({1'b0, syn_chk} > {1'b0, cfg.n});
    flip = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      flip[p-1] = (syn_chk == SYN_W'(p));
    end
    chk_cw = word & mask;
    if (!oor) begin
      chk_cw = chk_cw ^ (flip & mask);
    end
  end

  // Result select
  always_comb begin
    res.parity_count = cfg.r;
    case (op)
      OP_ENCODE: begin
        res.code_word    = enc_cw & mask;
        res.syndrome     = '0;
        res.out_of_range = 1'b0;
      end
      OP_CHECK: begin
        res.code_word    = chk_cw;
        res.syndrome     = syn_chk;
        res.out_of_range = oor;
      end
      default: begin
        res.code_word    = '0;
        res.syndrome     = '0;
        res.out_of_range = 1'b0;
      end
    endcase
  end

endmodule
